@@ src/ryp_pkg.sv @@
// Shared constants and coefficient tables for the RGB to YPbPr converter.
`default_nettype none

package ryp_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int CFG_W           = 16;
  localparam int OUT_W           = 16;
  localparam int COEF_W          = 20;
  localparam int DEN_W           = COEF_W + CFG_W;
  localparam int ACC_W           = DEN_W + 2;
  localparam int NUM_ROWS        = 3;
  localparam int NUM_COLS        = 3;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 15;

  localparam int ROW_Y           = 0;
  localparam int ROW_PB          = 1;
  localparam int ROW_PR          = 2;

  localparam int COL_R           = 0;
  localparam int COL_G           = 1;
  localparam int COL_B           = 2;

  localparam logic [COEF_W-1:0] COEF_ONE      = 20'd1000000;
  localparam logic [CFG_W-1:0]  MAX_VALUE_RST = 16'd255;

  localparam logic [OUT_W-1:0] LUMA_SAT   = 16'hFFFF;
  localparam logic [OUT_W-1:0] CHROMA_POS = 16'h7FFF;
  localparam logic [OUT_W-1:0] CHROMA_NEG = 16'h8000;

  // Coefficient magnitudes in millionths, row by row (Y, Pb, Pr), columns R, G, B.
  localparam logic [COEF_W-1:0] COEF_MAG [NUM_ROWS][NUM_COLS] = '{
    '{20'd299000, 20'd587000, 20'd114000},
    '{20'd168736, 20'd331264, 20'd500000},
    '{20'd500000, 20'd418688, 20'd81312}
  };

  // Bit c set: column c enters its row with a minus sign.
  localparam logic [NUM_COLS-1:0] COEF_NEG [NUM_ROWS] = '{
    3'b000,
    3'b011,
    3'b110
  };

endpackage

`default_nettype wire

@@ src/ryp_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
`default_nettype none

module ryp_div #(
  parameter int FRAC_BITS = ryp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic [ryp_pkg::DEN_W+FRAC_BITS:0] num_i,
  input  wire logic [ryp_pkg::DEN_W-1:0]         den_i,
  output logic      [FRAC_BITS:0]                quo_o
);
  import ryp_pkg::*;

  localparam int QB = FRAC_BITS + 1;
  localparam int NW = DEN_W + QB;

  logic [DEN_W-1:0] rem_q [QB-1];
  logic [QB-1:0]    lo_q  [QB-1];
  logic [QB-1:0]    quo_q [QB];

  // num_i < den_i * 2^QB, so the top DEN_W bits already sit below the divisor.
  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QB-1:0]    lo_in;
    logic [QB-1:0]    quo_in;
    logic [DEN_W:0]   trial;
    logic             fits;

    if (j == 0) begin : g_first
      assign rem_in = num_i[NW-1:QB];
      assign lo_in  = num_i[QB-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign lo_in  = lo_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial = {rem_in, lo_in[QB-1]};
    assign fits  = (trial >= {1'b0, den_i});

    always_ff @(posedge clk_i) begin
      quo_q[j] <= {quo_in[QB-2:0], fits};
    end

    if (j < QB - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[j] <= fits ? DEN_W'(trial - {1'b0, den_i}) : DEN_W'(trial);
        lo_q[j]  <= {lo_in[QB-2:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

`default_nettype wire

@@ src/rgb_to_ypbpr_convert.sv @@
// Top level: pipelined BT.601 RGB to YPbPr pixel converter.
//
// Usage:
//   Pixel in: drive red/green/blue_sample_i and raise start. busy is always
//   low, so an item is taken at every rising edge with start high: one pixel
//   per clock, sustained, with no gaps between items.
//   Result out: result_valid_o is high for exactly one cycle with luma_o,
//   chroma_blue_o and chroma_red_o (Y, Pb, Pr scaled by 2^FRAC_BITS, rounded
//   to nearest, samples clamped to max_value). Items leave in order.
//   Pipeline: an item taken with start high passes five front-end stages
//   (clamp, multiply, sum, magnitude, numerator), then the divider, which
//   resolves one quotient bit per stage, then the output register, before it
//   shows on the result ports.
//   Configuration: cfg_data_i is written into max_value when cfg_valid_i is
//   high (cfg_ready_o is always high). Write it only with no item in flight.
//   Reset: max_value returns to 255 and all in-flight items are dropped.
//   The receiver cannot stall; no output buffering beyond the result register.
`default_nettype none

module rgb_to_ypbpr_convert #(
  parameter int SAMPLE_BITS = ryp_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ryp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ryp_pkg::SAMPLE_W-1:0]   red_sample_i,
  input  wire logic [ryp_pkg::SAMPLE_W-1:0]   green_sample_i,
  input  wire logic [ryp_pkg::SAMPLE_W-1:0]   blue_sample_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ryp_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                                result_valid_o,
  output logic      [ryp_pkg::OUT_W-1:0]      luma_o,
  output logic signed [ryp_pkg::OUT_W-1:0]    chroma_blue_o,
  output logic signed [ryp_pkg::OUT_W-1:0]    chroma_red_o
);
  import ryp_pkg::*;

  localparam int QB     = FRAC_BITS + 1;
  localparam int NW     = DEN_W + QB;
  localparam int PROD_W = COEF_W + SAMPLE_BITS;
  localparam int NSTG   = 5 + QB;

  logic                   accept;
  logic [CFG_W-1:0]       max_value_q;
  logic [CFG_W-1:0]       max_eff;
  logic [DEN_W-1:0]       den_q;
  logic [NSTG-1:0]        vld_q;

  logic [SAMPLE_W-1:0]    sample_in [NUM_COLS];
  logic [SAMPLE_BITS-1:0] smp_d [NUM_COLS];
  logic [SAMPLE_BITS-1:0] smp_q [NUM_COLS];

  logic [PROD_W-1:0]      prod_q [NUM_ROWS][NUM_COLS];
  logic [ACC_W-1:0]       acc_d  [NUM_ROWS];
  logic [ACC_W-1:0]       acc_q  [NUM_ROWS];
  logic [DEN_W-1:0]       mag_q  [NUM_ROWS];
  logic [NW-1:0]          num_q  [NUM_ROWS];
  logic [QB-1:0]          quo    [NUM_ROWS];
  logic [NUM_ROWS-1:0]    neg_q  [QB+2];

  logic                   result_valid_q;
  logic [OUT_W-1:0]       luma_d, luma_q;
  logic [OUT_W-1:0]       cb_d, cb_q;
  logic [OUT_W-1:0]       cr_d, cr_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Configuration register and the divisor it implies.
  assign max_eff = (max_value_q == '0) ? CFG_W'(1) : max_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MAX_VALUE_RST;
      den_q       <= DEN_W'(COEF_ONE) * DEN_W'(MAX_VALUE_RST);
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_value_q <= cfg_data_i;
      end
      den_q <= DEN_W'(COEF_ONE) * DEN_W'(max_eff);
    end
  end

  // Valid bits follow the data down the pipe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q          <= '0;
      result_valid_q <= 1'b0;
    end else begin
      vld_q          <= {vld_q[NSTG-2:0], accept};
      result_valid_q <= vld_q[NSTG-1];
    end
  end

  // Stage 1: mask to SAMPLE_BITS and clamp to max_value.
  assign sample_in[COL_R] = red_sample_i;
  assign sample_in[COL_G] = green_sample_i;
  assign sample_in[COL_B] = blue_sample_i;

  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      if (SAMPLE_W'(sample_in[c][SAMPLE_BITS-1:0]) > SAMPLE_W'(max_eff)) begin
        smp_d[c] = SAMPLE_BITS'(max_eff);
      end else begin
        smp_d[c] = sample_in[c][SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
  end

  // Stage 2: coefficient products.
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        prod_q[r][c] <= PROD_W'(COEF_MAG[r][c]) * PROD_W'(smp_q[c]);
      end
    end
  end

  // Stage 3: signed row sums.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      acc_d[r] = '0;
      for (int c = 0; c < NUM_COLS; c++) begin
        if (COEF_NEG[r][c]) begin
          acc_d[r] = acc_d[r] - ACC_W'(prod_q[r][c]);
        end else begin
          acc_d[r] = acc_d[r] + ACC_W'(prod_q[r][c]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Stage 4: magnitude and sign; sign rides alongside to the output.
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      neg_q[0][r] <= acc_q[r][ACC_W-1];
      mag_q[r]    <= acc_q[r][ACC_W-1] ? DEN_W'(ACC_W'(0) - acc_q[r]) : DEN_W'(acc_q[r]);
    end
    for (int k = 1; k < QB + 2; k++) begin
      neg_q[k] <= neg_q[k-1];
    end
  end

  // Stage 5: numerator with half the divisor added for round-half-away.
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      num_q[r] <= (NW'(mag_q[r]) << FRAC_BITS) + NW'(den_q >> 1);
    end
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    ryp_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .num_i (num_q[r]),
      .den_i (den_q),
      .quo_o (quo[r])
    );
  end

  function automatic logic [OUT_W-1:0] sat_luma(input logic [QB-1:0] q, input logic n);
    logic [31:0] qx;
    qx = 32'(q);
    if (n) begin
      return '0;
    end else if (qx > 32'd65535) begin
      return LUMA_SAT;
    end
    return qx[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sat_chroma(input logic [QB-1:0] q, input logic n);
    logic [31:0] qx;
    qx = 32'(q);
    if (!n) begin
      return (qx > 32'd32767) ? CHROMA_POS : qx[OUT_W-1:0];
    end
    return (qx > 32'd32768) ? CHROMA_NEG : OUT_W'(32'd0 - qx);
  endfunction

  // Output stage: restore sign and saturate to the 16-bit fields.
  always_comb begin
    luma_d = sat_luma(quo[ROW_Y], neg_q[QB+1][ROW_Y]);
    cb_d   = sat_chroma(quo[ROW_PB], neg_q[QB+1][ROW_PB]);
    cr_d   = sat_chroma(quo[ROW_PR], neg_q[QB+1][ROW_PR]);
  end

  always_ff @(posedge clk_i) begin
    luma_q <= luma_d;
    cb_q   <= cb_d;
    cr_q   <= cr_d;
  end

  assign result_valid_o = result_valid_q;
  assign luma_o         = luma_q;
  assign chroma_blue_o  = cb_q;
  assign chroma_red_o   = cr_q;

`ifndef SYNTH
  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, NSTG + 1))
    else $error("result without a matching item");

  a_luma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (int'(luma_o) <= ((FRAC_BITS >= 16) ? 65535 : (1 << FRAC_BITS))))
    else $error("luma above full scale");

  a_chroma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (int'(chroma_blue_o) <= ((FRAC_BITS >= 16) ? 32767 : (1 << (FRAC_BITS - 1))) &&
       int'(chroma_blue_o) >= ((FRAC_BITS >= 16) ? -32768 : -(1 << (FRAC_BITS - 1))) &&
       int'(chroma_red_o) <= ((FRAC_BITS >= 16) ? 32767 : (1 << (FRAC_BITS - 1))) &&
       int'(chroma_red_o) >= ((FRAC_BITS >= 16) ? -32768 : -(1 << (FRAC_BITS - 1)))))
    else $error("chroma outside half scale");
`endif

endmodule

`default_nettype wire
